[rtl/lsls_pkg.sv]
// ----------------------------------------------------------------------------
// lsls_pkg
// Shared codes, defaults and types for the searchable LIFO stack.
// ----------------------------------------------------------------------------
package lsls_pkg;

    // Request codes
    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Field widths fixed by the interface
    localparam int WORD_W = 32;
    localparam int POS_W  = 4;

    // Default stack depth
    localparam int DEPTH_DEF = 16;

    // Cells examined per scan cycle
    localparam int SCAN_W = 16;

    // Command broadcast to every cell
    typedef struct packed {
        logic push;     // shift toward the bottom, load new top
        logic pop;      // shift toward the top
        logic capture;  // latch the compare result
    } cell_cmd_t;

    // Scanner status back to the control
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

[rtl/lsls_cell.sv]
// ----------------------------------------------------------------------------
// lsls_cell
// One stack slot: holds a word and its valid bit, shifts with its neighbors
// on push and pop, and latches an equality compare against the search key.
// ----------------------------------------------------------------------------
module lsls_cell
    import lsls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_cmd_t         cmd,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] up_data,     // neighbor nearer the top
    input  logic              up_valid,
    input  logic [WORD_W-1:0] down_data,   // neighbor nearer the bottom
    input  logic              down_valid,
    output logic [WORD_W-1:0] data,
    output logic              valid,
    output logic              match
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;
    logic              match_reg;
    logic              match_next;

    // Pick the next slot contents
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (cmd.push)
        begin
            data_next  = up_data;
            valid_next = up_valid;
        end
        else if (cmd.pop)
        begin
            data_next  = down_data;
            valid_next = down_valid;
        end
        if (cmd.capture)
        begin
            match_next = valid_reg && (data_reg == key);
        end
    end

    // Hold control bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

[rtl/lsls_scan.sv]
// ----------------------------------------------------------------------------
// lsls_scan
// Finds the deepest cell with a latched match, one group of SCAN_W cells per
// cycle, starting from the deepest group.
// ----------------------------------------------------------------------------
module lsls_scan
    import lsls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DEPTH-1:0]           match,
    output scan_stat_t                 stat,
    output logic [$clog2(DEPTH)-1:0]   idx
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int GROUPS = (DEPTH + SCAN_W - 1) / SCAN_W;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD_W  = GROUPS * SCAN_W;
    localparam int SEL_W  = $clog2(SCAN_W);
    localparam int SUM_W  = GRP_W + SEL_W;

    logic               busy_reg;
    logic               busy_next;
    logic [GRP_W-1:0]   grp_reg;
    logic [GRP_W-1:0]   grp_next;
    logic [PAD_W-1:0]   match_pad;
    logic [SCAN_W-1:0]  grp_bits;
    logic [SEL_W-1:0]   sel;
    logic               any;
    logic [SUM_W-1:0]   flat;

    assign match_pad = {{(PAD_W - DEPTH){1'b0}}, match};
    assign grp_bits  = match_pad[grp_reg * SCAN_W +: SCAN_W];

    // Highest set bit within the current group
    always_comb
    begin
        sel = '0;
        any = 1'b0;
        for (int b = 0; b < SCAN_W; b++)
        begin
            if (grp_bits[b])
            begin
                sel = SEL_W'(b);
                any = 1'b1;
            end
        end
    end

    assign flat = {grp_reg, sel};
    assign idx  = flat[IDX_W-1:0];

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (any || (grp_reg == '0));
    assign stat.hit  = busy_reg && any;

    // Advance to the next shallower group
    always_comb
    begin
        busy_next = busy_reg;
        grp_next  = grp_reg;
        if (start)
        begin
            busy_next = 1'b1;
            grp_next  = GRP_W'(GROUPS - 1);
        end
        else if (stat.done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            grp_next = grp_reg - GRP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            grp_reg  <= grp_next;
        end
    end

endmodule

[rtl/searchable_lifo_stack.sv]
// ----------------------------------------------------------------------------
// searchable_lifo_stack
// Bounded LIFO of 32-bit words with push, pop and search by value.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_stall  | mode, value
//  out     | output    | out_valid / out_stall| popped_value, found, position,
//          |           |                      | status, occupancy
//
//  Push, pop, no-op and empty-stack search requests load the result register
//  at the accepting edge. A search on a non-empty stack latches a compare in
//  every cell on the accepting edge, then the scanner walks up to ceil(DEPTH/16)
//  groups of cells, one per cycle, deepest first, stopping at the first hit.
//  Reset clears the valid bits and the count; the stack is empty at once.
//  A new beat is taken while no scan runs and the result register is free or
//  being drained; a stalled result holds the input side as well.
// ----------------------------------------------------------------------------
module searchable_lifo_stack
    import lsls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic signed [WORD_W-1:0]     value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [WORD_W-1:0]     popped_value,
    output logic                         found,
    output logic [POS_W-1:0]             position,
    output logic [1:0]                   status,
    output logic [$clog2(DEPTH+1)-1:0]   occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [WORD_W-1:0]  popped_reg;
    logic [WORD_W-1:0]  popped_next;
    logic               found_reg;
    logic               found_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;

    logic               accept;
    logic               load;
    logic               full;
    logic               empty;
    logic               scan_start;
    cell_cmd_t          cmd;
    scan_stat_t         scan_stat;
    logic [IDX_W-1:0]   scan_idx;
    logic [CNT_W-1:0]   pos_full;
    logic [CNT_W+POS_W-1:0] pos_ext;

    logic [WORD_W-1:0]  cell_data  [DEPTH];
    logic               cell_valid [DEPTH];
    logic [DEPTH-1:0]   cell_match;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign in_stall = (state_reg == S_SCAN) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // Decode the accepted beat into a cell command
    always_comb
    begin
        cmd        = '0;
        scan_start = 1'b0;
        if (accept)
        begin
            unique case (mode)
                MODE_PUSH:   cmd.push = !full;
                MODE_POP:    cmd.pop  = !empty;
                MODE_SEARCH:
                begin
                    cmd.capture = !empty;
                    scan_start  = !empty;
                end
                default:     cmd = '0;
            endcase
        end
    end

    // Row of cells: cell 0 is the top of the stack
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [WORD_W-1:0] up_data;
        logic              up_valid;
        logic [WORD_W-1:0] down_data;
        logic              down_valid;

        if (k == 0)
        begin : g_top
            assign up_data  = value;
            assign up_valid = 1'b1;
        end
        else
        begin : g_mid
            assign up_data  = cell_data[k-1];
            assign up_valid = cell_valid[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_bot
            assign down_data  = '0;
            assign down_valid = 1'b0;
        end
        else
        begin : g_inner
            assign down_data  = cell_data[k+1];
            assign down_valid = cell_valid[k+1];
        end

        lsls_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .key        (value),
            .up_data    (up_data),
            .up_valid   (up_valid),
            .down_data  (down_data),
            .down_valid (down_valid),
            .data       (cell_data[k]),
            .valid      (cell_valid[k]),
            .match      (cell_match[k])
        );
    end

    lsls_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .match (cell_match),
        .stat  (scan_stat),
        .idx   (scan_idx)
    );

    // Cell k holds the entry at count-1-k from the bottom
    assign pos_full = count_reg - CNT_W'(1) - CNT_W'(scan_idx);
    assign pos_ext  = {{POS_W{1'b0}}, pos_full};

    // Build the next result and the next count
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        load        = 1'b0;
        popped_next = popped_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        status_next = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load        = !scan_start;
                    popped_next = '0;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    status_next = ST_OK;
                    case (mode)
                        MODE_PUSH:
                        begin
                            if (full)
                                status_next = ST_OVERFLOW;
                            else
                                count_next = count_reg + CNT_W'(1);
                        end
                        MODE_POP:
                        begin
                            if (empty)
                                status_next = ST_UNDERFLOW;
                            else
                            begin
                                count_next  = count_reg - CNT_W'(1);
                                popped_next = cell_data[0];
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (empty)
                                status_next = ST_UNDERFLOW;
                            else
                                state_next = S_SCAN;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    load        = 1'b1;
                    state_next  = S_IDLE;
                    popped_next = '0;
                    found_next  = scan_stat.hit;
                    pos_next    = scan_stat.hit ? pos_ext[POS_W-1:0] : '0;
                    status_next = ST_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drain or load the result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only with a new beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            popped_reg <= popped_next;
            found_reg  <= found_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    // Occupancy travels with its result
    logic [CNT_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            occ_reg <= count_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign position     = pos_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

endmodule

[rtl/lsls_check.sv]
// ----------------------------------------------------------------------------
// lsls_check
// Port-level checks on the searchable LIFO stack, bound to the top level.
// ----------------------------------------------------------------------------
module lsls_check
    import lsls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [1:0]                   mode,
    input logic signed [WORD_W-1:0]     value,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [WORD_W-1:0]     popped_value,
    input logic                         found,
    input logic [POS_W-1:0]             position,
    input logic [1:0]                   status,
    input logic [$clog2(DEPTH+1)-1:0]   occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Overflow only when the stack is full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> (occupancy == CNT_W'(DEPTH)))
        else $error("overflow reported with room left");

    // Underflow only when the stack is empty
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDERFLOW) |-> (occupancy == '0))
        else $error("underflow reported on a non-empty stack");

    // A hit lies inside the occupied range and carries no error
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |->
            (status == ST_OK && CNT_W'(position) < occupancy))
        else $error("search hit outside the valid entries");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(popped_value) && $stable(occupancy)))
        else $error("stalled result changed");

    // A stalled request beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=>
            (in_valid && $stable(mode) && $stable(value)))
        else $error("stalled request changed");

endmodule

bind searchable_lifo_stack lsls_check #(.DEPTH(DEPTH)) u_lsls_check (.*);

[bench/tb_searchable_lifo_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_searchable_lifo_stack
// Self-checking bench for the searchable LIFO stack. A request queue feeds a
// clocked driver; each accepted request updates a local stack model, which
// predicts the result beat. A clocked monitor checks every result beat, field
// by field, against the oldest prediction. Directed requests cover the
// corner cases; random episodes fill, drain and search the stack under
// several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_searchable_lifo_stack;
    import lsls_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int NUM_RANDOM = 500;

    // Mode code left unused by the block; it must act as a no-op
    localparam logic [1:0] MODE_NOP = 2'd3;

    typedef struct {
        logic [1:0]               mode;
        logic signed [WORD_W-1:0] value;
        bit                       drain;   // wait for all results before sending
    } stack_req_t;

    typedef struct {
        logic signed [WORD_W-1:0] popped_value;
        logic                     found;
        logic [POS_W-1:0]         position;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } stack_res_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               mode = MODE_PUSH;
    logic signed [WORD_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [WORD_W-1:0] popped_value;
    logic                     found;
    logic [POS_W-1:0]         position;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    stack_req_t req_queue[$];
    stack_res_t pending_results[$];

    // Local stack model
    logic signed [WORD_W-1:0] model_mem [DEPTH];
    int                       model_cnt = 0;

    int idle_pct = 0;
    int stall_pct = 0;
    int n_sent = 0;
    int n_checked = 0;
    int err_cnt = 0;
    int n_push = 0, n_pop = 0, n_search = 0, n_hit = 0, n_over = 0, n_under = 0;

    stack_res_t mon_exp;

    searchable_lifo_stack #(.DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .found        (found),
        .position     (position),
        .status       (status),
        .occupancy    (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the stack model and return its result
    function automatic stack_res_t lifo_predict(input logic [1:0] m,
                                                input logic signed [WORD_W-1:0] v);
        stack_res_t r;
        bit         hit;
        r.popped_value = '0;
        r.found        = 1'b0;
        r.position     = '0;
        r.status       = ST_OK;
        hit            = 0;
        case (m)
            MODE_PUSH:
            begin
                n_push++;
                if (model_cnt >= DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                    n_over++;
                end
                else
                begin
                    model_mem[model_cnt] = v;
                    model_cnt++;
                end
            end
            MODE_POP:
            begin
                n_pop++;
                if (model_cnt == 0)
                begin
                    r.status = ST_UNDERFLOW;
                    n_under++;
                end
                else
                begin
                    model_cnt--;
                    r.popped_value = model_mem[model_cnt];
                end
            end
            MODE_SEARCH:
            begin
                n_search++;
                if (model_cnt == 0)
                begin
                    r.status = ST_UNDERFLOW;
                    n_under++;
                end
                else
                begin
                    // lowest valid match wins
                    for (int i = 0; i < model_cnt; i++)
                    begin
                        if (!hit && model_mem[i] === v)
                        begin
                            hit        = 1;
                            r.found    = 1'b1;
                            r.position = i[POS_W-1:0];
                        end
                    end
                    if (hit)
                        n_hit++;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = model_cnt[OCC_W-1:0];
        return r;
    endfunction

    // Driver: take accepted beats, then present the next request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(lifo_predict(mode, value));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_queue.size() > 0 &&
                    (!req_queue[0].drain || pending_results.size() == 0) &&
                    $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    mode     <= req_queue[0].mode;
                    value    <= req_queue[0].value;
                    void'(req_queue.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                err_cnt++;
            end
            else
            begin
                mon_exp = pending_results.pop_front();
                n_checked++;
                if (popped_value !== mon_exp.popped_value)
                begin
                    $error("popped_value: expected %0d, got %0d",
                           mon_exp.popped_value, popped_value);
                    err_cnt++;
                end
                if (found !== mon_exp.found)
                begin
                    $error("found: expected %0d, got %0d", mon_exp.found, found);
                    err_cnt++;
                end
                if (position !== mon_exp.position)
                begin
                    $error("position: expected %0d, got %0d", mon_exp.position, position);
                    err_cnt++;
                end
                if (status !== mon_exp.status)
                begin
                    $error("status: expected %0d, got %0d", mon_exp.status, status);
                    err_cnt++;
                end
                if (occupancy !== mon_exp.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d",
                           mon_exp.occupancy, occupancy);
                    err_cnt++;
                end
            end
        end
    end

    task automatic add_req(input logic [1:0] m, input logic signed [WORD_W-1:0] v,
                           input bit drain);
        stack_req_t q;
        q.mode  = m;
        q.value = v;
        q.drain = drain;
        req_queue.push_back(q);
    endtask

    // Small set of values that repeat, so searches hit duplicates
    function automatic logic signed [WORD_W-1:0] pool_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            4: return 32'sd1;
            default: return $urandom_range(3);
        endcase
    endfunction

    // Random episodes: fill, drain or mixed, with searches for pushed words
    task automatic build_random();
        logic signed [WORD_W-1:0] recent [32];
        int n_recent;
        int gen_depth;
        int bias;
        int ep_len;
        int push_pct;
        int pop_pct;
        int r;
        bit drain;
        logic signed [WORD_W-1:0] v;
        n_recent  = 0;
        gen_depth = 0;
        bias      = 0;
        ep_len    = 40;
        drain     = 1;
        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            if (ep_len == 0)
            begin
                bias   = $urandom_range(2);
                ep_len = $urandom_range(40, 16);
                drain  = ($urandom_range(3) == 0);
            end
            ep_len--;
            push_pct = (bias == 0) ? 80 : (bias == 1) ? 10 : 40;
            pop_pct  = (bias == 0) ? 8 : (bias == 1) ? 70 : 30;
            r = $urandom_range(99);
            if (r < 3)
            begin
                add_req(MODE_NOP, $urandom, drain);
            end
            else if (r < 3 + push_pct)
            begin
                v = ($urandom_range(9) < 3) ? pool_value() : $urandom;
                recent[n_recent % 32] = v;
                n_recent++;
                if (gen_depth < DEPTH)
                    gen_depth++;
                add_req(MODE_PUSH, v, drain);
            end
            else if (r < 3 + push_pct + pop_pct)
            begin
                if (gen_depth > 0)
                    gen_depth--;
                add_req(MODE_POP, $urandom, drain);
            end
            else
            begin
                if (n_recent > 0 && $urandom_range(9) < 6)
                    v = recent[$urandom_range((n_recent < 32 ? n_recent : 32) - 1)];
                else if ($urandom_range(1) == 0)
                    v = pool_value();
                else
                    v = $urandom;
                add_req(MODE_SEARCH, v, drain);
            end
            drain = 0;
        end
    endtask

    // Stimulus and phase control
    initial
    begin
        int total;
        // directed corner cases
        add_req(MODE_POP,    32'sd0, 0);           // pop when empty
        add_req(MODE_SEARCH, 32'sd0, 0);           // search when empty
        add_req(MODE_NOP,    -32'sd1, 0);          // unused code on empty stack
        add_req(MODE_PUSH,   32'sh8000_0000, 0);
        add_req(MODE_PUSH,   32'sh7fff_ffff, 0);
        add_req(MODE_PUSH,   -32'sd1, 0);
        add_req(MODE_PUSH,   32'sd0, 0);
        add_req(MODE_PUSH,   -32'sd1, 0);          // duplicate above a match
        add_req(MODE_SEARCH, -32'sd1, 0);          // lowest of two matches
        add_req(MODE_SEARCH, 32'sh8000_0000, 0);   // bottom entry
        add_req(MODE_SEARCH, 32'sd0, 0);
        add_req(MODE_SEARCH, 32'sd5, 0);           // miss
        add_req(MODE_NOP,    -32'sd1, 0);          // no-op with data bits set
        add_req(MODE_POP,    32'sh5555_aaaa, 1);
        add_req(MODE_POP,    32'sd0, 0);
        add_req(MODE_SEARCH, 32'sd0, 0);           // popped word no longer valid
        add_req(MODE_POP,    32'sd0, 0);
        add_req(MODE_POP,    32'sd0, 0);
        add_req(MODE_POP,    32'sd0, 0);
        add_req(MODE_POP,    32'sd0, 0);           // underflow after drain
        add_req(MODE_SEARCH, 32'sh7fff_ffff, 0);   // search after drain
        build_random();
        total = req_queue.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // idle phases: none, sender idle, receiver stall, both
        idle_pct = 0;  stall_pct = 0;
        while (n_sent < total / 5) @(posedge clk);
        idle_pct = 75; stall_pct = 0;
        while (n_sent < 2 * total / 5) @(posedge clk);
        idle_pct = 0;  stall_pct = 75;
        while (n_sent < 3 * total / 5) @(posedge clk);
        idle_pct = 12; stall_pct = 12;
        while (n_sent < 4 * total / 5) @(posedge clk);
        idle_pct = 0;  stall_pct = 0;

        // drain everything, then allow for the search latency
        while (req_queue.size() != 0 || in_valid) @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_results.size());
            err_cnt++;
        end

        $display("Checked %0d result beats from %0d requests: %0d push, %0d pop, %0d search",
                 n_checked, n_sent, n_push, n_pop, n_search);
        $display("Search hits %0d, overflows %0d, underflows %0d", n_hit, n_over, n_under);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/lsls_pkg.sv
rtl/lsls_cell.sv
rtl/lsls_scan.sv
rtl/searchable_lifo_stack.sv
rtl/lsls_check.sv
bench/tb_searchable_lifo_stack.sv
